// ----- rtl/mipmap_texture_sampler_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the mipmap texture sampler
// Shared property forms, clocked on aclk and disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef MIPMAP_TEXTURE_SAMPLER_DEFINES_SVH
`define MIPMAP_TEXTURE_SAMPLER_DEFINES_SVH

// Condition in this cycle implies check in the next cycle.
`define MTX_ASSERT_NEXT(lbl, cond, chk) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (chk)) \
        else $error("mtx check failed");

// Condition in this cycle implies check in the same cycle.
`define MTX_ASSERT_NOW(lbl, cond, chk) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (chk)) \
        else $error("mtx check failed");

`endif

// ----- rtl/mtx_pkg.sv -----
// ----------------------------------------------------------------------------
// mtx_pkg
// Types, constants and address helpers of the mipmap texture sampler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mtx_pkg;

    localparam int MAX_DIM    = 256;
    localparam int MAX_LEVELS = 9;
    localparam int MEM_WORDS  = 131072;

    localparam int DIM_W   = $clog2(MAX_DIM + 1);     // size 1..MAX_DIM
    localparam int COORD_W = DIM_W - 1;               // texel index
    localparam int FULL_W  = 2 * DIM_W + 1;           // unbounded word address
    localparam int ADDR_W  = $clog2(MEM_WORDS);
    localparam int MAG_W   = DIM_W + 17;              // |size * derivative|
    localparam int SUM_W   = 2 * MAG_W + 1;           // squared length
    localparam int E_W     = $clog2(SUM_W);           // top-bit exponent
    localparam int LVL8_W  = 12;                      // level, 8 fraction bits
    localparam int ACC_W   = 48;                      // channel sum, 40 fraction bits
    localparam int QDEPTH  = 2;

    localparam logic [16:0] ONE16     = 17'h10000;
    localparam logic [8:0]  ONE8      = 9'h100;
    localparam logic [15:0] HALF_TEX  = 16'h8000;

    // register indexes
    localparam logic [2:0] REG_BASE_WIDTH   = 3'd0;
    localparam logic [2:0] REG_BASE_HEIGHT  = 3'd1;
    localparam logic [2:0] REG_LEVEL_COUNT  = 3'd2;
    localparam logic [2:0] REG_PIXEL_METHOD = 3'd3;
    localparam logic [2:0] REG_LEVEL_METHOD = 3'd4;

    localparam logic       CMD_WRITE  = 1'b0;
    localparam logic       CMD_SAMPLE = 1'b1;
    localparam logic       PM_NEAREST  = 1'b0;
    localparam logic       PM_BILINEAR = 1'b1;
    localparam logic [1:0] LM_BASE    = 2'd0;
    localparam logic [1:0] LM_NEAREST = 2'd1;
    localparam logic [1:0] LM_LINEAR  = 2'd2;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [3:0]       levels;
        logic             pixel_method;
        logic [1:0]       level_method;
    } cfg_t;

    typedef struct packed {
        logic               command;
        logic [3:0]         write_level;
        logic [7:0]         write_x;
        logic [7:0]         write_y;
        logic [31:0]        texel_value;
        logic [15:0]        coord_u;
        logic [15:0]        coord_v;
        logic signed [17:0] du_dx;
        logic signed [17:0] dv_dx;
        logic signed [17:0] du_dy;
        logic signed [17:0] dv_dy;
    } item_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_WRITE,
        BK_SCALE,
        BK_SQUARE,
        BK_NORM,
        BK_LOG,
        BK_PICK,
        BK_SETUP,
        BK_ADDR,
        BK_WEIGHT,
        BK_ACCUM,
        BK_DONE
    } bk_state_t;

    // side of the square region that holds level lv
    function automatic logic [DIM_W-1:0] region_side(input logic [3:0] lv);
        logic [DIM_W-1:0] s;
        s = DIM_W'(MAX_DIM >> lv);
        return (s == '0) ? DIM_W'(1) : s;
    endfunction

    // first word of level lv
    function automatic logic [FULL_W-1:0] region_start(input logic [3:0] lv);
        logic [FULL_W-1:0] acc;
        logic [DIM_W-1:0]  sd;
        acc = '0;
        for (int k = 0; k < 16; k++) begin
            sd = region_side(4'(k));
            if (4'(k) < lv) begin
                acc = acc + FULL_W'(sd) * FULL_W'(sd);
            end
        end
        return acc;
    endfunction

    // size of level lv, never below one texel
    function automatic logic [DIM_W-1:0] level_size(input logic [DIM_W-1:0] size,
                                                    input logic [3:0] lv);
        logic [DIM_W-1:0] s;
        s = size >> lv;
        return (s == '0) ? DIM_W'(1) : s;
    endfunction

endpackage

// ----- rtl/mipmap_texture_sampler.sv -----
// ----------------------------------------------------------------------------
// mipmap_texture_sampler
// Mipmapped RGBA8 texture unit with nearest, bilinear and trilinear filtering.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one beat is either a texel write (s_tuser low) or a sample
//   request (s_tuser high). Writes store one texel of the mip chain and give
//   no result; each sample gives exactly one RGBA8 beat on m_*, in order.
//   cfg_* channel: register writes, always ready; write only while idle.
// Sequencing:
//   Items run one at a time through a sequencer that owns the single-port
//   texel memory. A write passes through the write state. A sample starts,
//   runs level selection when a mip mode is active (a scale and a square
//   step for each of the four derivatives, then normalize steps and 9 log
//   steps unless the squares are all zero), picks the levels, sets up each
//   level, reads each texel in an address, a weight and an accumulate step
//   and skips each texel of zero weight (4 texel slots per level), then
//   loads the result.
//   A two-entry queue behind the input lets the next beats be taken meanwhile.
// Reset: aresetn (synchronous, active low) restores the default registers
//   and empties queue and result register; texel memory keeps its contents.
// Stall: a result waits in the output register while m_tready is low; the
//   sequencer holds its next result until the register frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mipmap_texture_sampler (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // s_tdata, low bit up: write_level[3:0] write_x[7:0] write_y[7:0]
    //   texel_value[31:0] coord_u[15:0] coord_v[15:0] du_dx[17:0] dv_dx[17:0]
    //   du_dy[17:0] dv_dy[17:0], then four zero bits
    input  logic [159:0] s_tdata,
    // s_tuser: command (0 write a texel, 1 sample)
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // m_tdata, low bit up: red[7:0] green[7:0] blue[7:0] alpha[7:0]
    output logic [31:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [8:0]   cfg_data
);

    mtx_pkg::item_t front_item, back_item;
    mtx_pkg::cfg_t  cfg;
    logic           front_valid, front_ready;
    logic           back_valid, back_pop;

    // register file and beat unpacking
    mtx_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_ready   (front_ready),
        .q_valid   (front_valid),
        .q_item    (front_item),
        .cfg       (cfg)
    );

    // decouple intake from the sequencer
    mtx_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_item  (front_item),
        .pop_valid  (back_valid),
        .pop_ready  (back_pop),
        .pop_item   (back_item)
    );

    // texel memory, filtering and output register
    mtx_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .q_valid  (back_valid),
        .q_pop    (back_pop),
        .q_item   (back_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ----- rtl/mtx_front.sv -----
// ----------------------------------------------------------------------------
// mtx_front
// Configuration registers and input beat unpacking into queue items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mtx_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [159:0]         s_tdata,
    input  logic                 s_tuser,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [8:0]           cfg_data,
    input  logic                 q_ready,
    output logic                 q_valid,
    output mtx_pkg::item_t       q_item,
    output mtx_pkg::cfg_t        cfg
);

    logic [8:0] base_width_reg;
    logic [8:0] base_height_reg;
    logic [3:0] level_count_reg;
    logic       pixel_method_reg;
    logic [1:0] level_method_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_width_reg   <= 9'd256;
            base_height_reg  <= 9'd256;
            level_count_reg  <= 4'd1;
            pixel_method_reg <= mtx_pkg::PM_BILINEAR;
            level_method_reg <= mtx_pkg::LM_BASE;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                mtx_pkg::REG_BASE_WIDTH:   base_width_reg   <= cfg_data;
                mtx_pkg::REG_BASE_HEIGHT:  base_height_reg  <= cfg_data;
                mtx_pkg::REG_LEVEL_COUNT:  level_count_reg  <= cfg_data[3:0];
                mtx_pkg::REG_PIXEL_METHOD: pixel_method_reg <= cfg_data[0];
                mtx_pkg::REG_LEVEL_METHOD: level_method_reg <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // clamp raw register values into their working ranges
    always_comb begin
        if (base_width_reg == '0) begin
            cfg.width = mtx_pkg::DIM_W'(1);
        end else if (32'(base_width_reg) > mtx_pkg::MAX_DIM) begin
            cfg.width = mtx_pkg::DIM_W'(mtx_pkg::MAX_DIM);
        end else begin
            cfg.width = mtx_pkg::DIM_W'(base_width_reg);
        end
        if (base_height_reg == '0) begin
            cfg.height = mtx_pkg::DIM_W'(1);
        end else if (32'(base_height_reg) > mtx_pkg::MAX_DIM) begin
            cfg.height = mtx_pkg::DIM_W'(mtx_pkg::MAX_DIM);
        end else begin
            cfg.height = mtx_pkg::DIM_W'(base_height_reg);
        end
        if (level_count_reg == '0) begin
            cfg.levels = 4'd1;
        end else if (32'(level_count_reg) > mtx_pkg::MAX_LEVELS) begin
            cfg.levels = 4'(mtx_pkg::MAX_LEVELS);
        end else begin
            cfg.levels = level_count_reg;
        end
        cfg.pixel_method = pixel_method_reg;
        cfg.level_method = (level_method_reg == mtx_pkg::LM_NEAREST ||
                            level_method_reg == mtx_pkg::LM_LINEAR) ?
                           level_method_reg : mtx_pkg::LM_BASE;
    end

    always_comb begin
        q_item.command     = s_tuser;
        q_item.write_level = s_tdata[3:0];
        q_item.write_x     = s_tdata[11:4];
        q_item.write_y     = s_tdata[19:12];
        q_item.texel_value = s_tdata[51:20];
        q_item.coord_u     = s_tdata[67:52];
        q_item.coord_v     = s_tdata[83:68];
        q_item.du_dx       = s_tdata[101:84];
        q_item.dv_dx       = s_tdata[119:102];
        q_item.du_dy       = s_tdata[137:120];
        q_item.dv_dy       = s_tdata[155:138];
    end

    assign q_valid  = s_tvalid;
    assign s_tready = q_ready;

endmodule

// ----- rtl/mtx_queue.sv -----
// ----------------------------------------------------------------------------
// mtx_queue
// Short item queue between the front and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mtx_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  mtx_pkg::item_t push_item,
    output logic           pop_valid,
    input  logic           pop_ready,
    output mtx_pkg::item_t pop_item
);

    localparam int PTR_W = $clog2(mtx_pkg::QDEPTH);

    mtx_pkg::item_t   store_reg [mtx_pkg::QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != (PTR_W + 1)'(mtx_pkg::QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = store_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (PTR_W + 1)'(do_push) - (PTR_W + 1)'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            store_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- rtl/mtx_back.sv -----
// ----------------------------------------------------------------------------
// mtx_back
// Texel memory, level selection and filtering sequencer, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mtx_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  mtx_pkg::cfg_t  cfg,
    input  logic           q_valid,
    output logic           q_pop,
    input  mtx_pkg::item_t q_item,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [31:0]    m_tdata
);

    localparam int DW = mtx_pkg::DIM_W;
    localparam int CW = mtx_pkg::COORD_W;
    localparam int PW = 16 + DW + 1;

    mtx_pkg::bk_state_t state_reg, state_next;

    logic [31:0] mem [mtx_pkg::MEM_WORDS];
    logic [31:0] rdata_reg;

    mtx_pkg::item_t            item_reg;
    logic [1:0]                dsel_reg;
    logic [mtx_pkg::MAG_W-1:0] mag_reg;
    logic [mtx_pkg::SUM_W-1:0] sx_reg, sy_reg, norm_reg;
    logic [mtx_pkg::E_W-1:0]   e_reg;
    logic [31:0]               m_reg;
    logic [8:0]                frac_reg;
    logic [3:0]                step_reg;
    logic                      lvl_zero_reg;
    logic [3:0]                lower_reg, upper_reg;
    logic [7:0]                ratio_reg;
    logic                      j_reg;
    logic [1:0]                k_reg;
    logic [CW-1:0]             x0_reg, x1_reg, y0_reg, y1_reg;
    logic [15:0]               au_reg, av_reg;
    logic                      inrange_reg;
    logic [32:0]               wxy_reg;
    logic [40:0]               w_reg;
    logic [31:0]               tex_reg;
    logic [mtx_pkg::ACC_W-1:0] acc_reg [4];
    logic                      m_tvalid_reg;
    logic [31:0]               m_tdata_reg;

    // ------------------------------------------------------------------ datapath comb
    logic signed [17:0]        d_sel;
    logic [DW-1:0]             size_sel;
    logic signed [mtx_pkg::MAG_W:0] sprod;
    logic [mtx_pkg::MAG_W-1:0] mag;
    logic [2*mtx_pkg::MAG_W-1:0] sq;
    logic [mtx_pkg::SUM_W-1:0] sy_new, s_max;
    logic [63:0]               msq;
    logic [32:0]               mtop;
    logic [mtx_pkg::E_W-1:0]   ediff;
    logic [12:0]               lvl_raw;
    logic [mtx_pkg::LVL8_W-1:0] lvl_top, lvl8;
    logic                      lg_pos;
    logic [mtx_pkg::LVL8_W-1:0] lvl_round;
    logic [3:0]                lv_cur;
    logic [DW-1:0]             wl, hl;
    logic [16+DW-1:0]          pu_raw, pv_raw;
    logic signed [PW-1:0]      pu, pv;
    logic signed [DW:0]        fu, fv, cu, cv;
    logic [CW-1:0]             nx, ny, bx0, bx1, by0, by1;
    logic [DW-1:0]             nx9, ny9;
    logic [CW-1:0]             xs, ys;
    logic [16:0]               wx, wy;
    logic [8:0]                wl8;
    logic                      skip, last_tex, need_upper;
    logic [DW-1:0]             side;
    logic [mtx_pkg::FULL_W-1:0] addr_full;
    logic                      addr_ok, wr_ok;
    logic                      mem_we;
    logic                      out_free;
    logic [31:0]               result;
    logic [48:0]               tprod [4];
    logic [mtx_pkg::ACC_W-1:0] rsum [4];

    always_comb begin
        unique case (dsel_reg)
            2'd0:    begin d_sel = item_reg.du_dx; size_sel = cfg.width;  end
            2'd1:    begin d_sel = item_reg.dv_dx; size_sel = cfg.height; end
            2'd2:    begin d_sel = item_reg.du_dy; size_sel = cfg.width;  end
            default: begin d_sel = item_reg.dv_dy; size_sel = cfg.height; end
        endcase
        sprod  = $signed({1'b0, size_sel}) * d_sel;
        mag    = sprod[mtx_pkg::MAG_W] ? mtx_pkg::MAG_W'(-sprod) : sprod[mtx_pkg::MAG_W-1:0];
        sq     = mag_reg * mag_reg;
        sy_new = sy_reg + mtx_pkg::SUM_W'(sq);
        s_max  = (sx_reg > sy_new) ? sx_reg : sy_new;
        // one squaring step of the log mantissa
        msq    = m_reg * m_reg;
        mtop   = msq[63:31];
        // level in 8 fraction bits, clamped to the top level present
        ediff   = e_reg - mtx_pkg::E_W'(32);
        lg_pos  = (32'(e_reg) > 32) || ((32'(e_reg) == 32) && (frac_reg != '0));
        lvl_raw = {ediff[mtx_pkg::E_W-2:0], frac_reg[8:1]};
        lvl_top = {cfg.levels - 4'd1, 8'd0};
        if (lvl_zero_reg || !lg_pos) begin
            lvl8 = '0;
        end else if (lvl_raw > 13'(lvl_top)) begin
            lvl8 = lvl_top;
        end else begin
            lvl8 = lvl_raw[mtx_pkg::LVL8_W-1:0];
        end
        lvl_round = lvl8 + mtx_pkg::LVL8_W'(128);
    end

    // per level texel positions and weights
    always_comb begin
        lv_cur = j_reg ? upper_reg : lower_reg;
        wl     = mtx_pkg::level_size(cfg.width, lv_cur);
        hl     = mtx_pkg::level_size(cfg.height, lv_cur);
        pu_raw = item_reg.coord_u * wl;
        pv_raw = item_reg.coord_v * hl;
        nx9    = pu_raw[16 +: DW];
        ny9    = pv_raw[16 +: DW];
        nx     = (nx9 > wl - 1'b1) ? CW'(wl - 1'b1) : nx9[CW-1:0];
        ny     = (ny9 > hl - 1'b1) ? CW'(hl - 1'b1) : ny9[CW-1:0];
        pu     = $signed({1'b0, pu_raw}) - $signed(PW'(mtx_pkg::HALF_TEX));
        pv     = $signed({1'b0, pv_raw}) - $signed(PW'(mtx_pkg::HALF_TEX));
        fu     = pu[PW-1:16];
        fv     = pv[PW-1:16];
        cu     = fu + $signed((DW + 1)'(pu[15:0] != '0));
        cv     = fv + $signed((DW + 1)'(pv[15:0] != '0));
        bx0    = fu[DW] ? '0 : fu[CW-1:0];
        by0    = fv[DW] ? '0 : fv[CW-1:0];
        bx1    = (cu[DW-1:0] > wl - 1'b1) ? CW'(wl - 1'b1) : cu[CW-1:0];
        by1    = (cv[DW-1:0] > hl - 1'b1) ? CW'(hl - 1'b1) : cv[CW-1:0];
    end

    // texel address, weight and sequencing of the texel loop
    always_comb begin
        xs         = k_reg[0] ? x1_reg : x0_reg;
        ys         = k_reg[1] ? y1_reg : y0_reg;
        wx         = k_reg[0] ? {1'b0, au_reg} : mtx_pkg::ONE16 - {1'b0, au_reg};
        wy         = k_reg[1] ? {1'b0, av_reg} : mtx_pkg::ONE16 - {1'b0, av_reg};
        wl8        = j_reg ? {1'b0, ratio_reg} : mtx_pkg::ONE8 - {1'b0, ratio_reg};
        skip       = (k_reg[0] && au_reg == '0) || (k_reg[1] && av_reg == '0);
        last_tex   = (k_reg == 2'd3);
        need_upper = !j_reg && (ratio_reg != '0);
        if (state_reg == mtx_pkg::BK_WRITE) begin
            side      = mtx_pkg::region_side(item_reg.write_level);
            addr_full = mtx_pkg::region_start(item_reg.write_level)
                      + mtx_pkg::FULL_W'(item_reg.write_y) * mtx_pkg::FULL_W'(side)
                      + mtx_pkg::FULL_W'(item_reg.write_x);
        end else begin
            side      = mtx_pkg::region_side(lv_cur);
            addr_full = mtx_pkg::region_start(lv_cur)
                      + mtx_pkg::FULL_W'(ys) * mtx_pkg::FULL_W'(side)
                      + mtx_pkg::FULL_W'(xs);
        end
        addr_ok = (32'(addr_full) < mtx_pkg::MEM_WORDS);
        wr_ok   = (32'(item_reg.write_level) < mtx_pkg::MAX_LEVELS)
               && (DW'(item_reg.write_x) < side) && (DW'(item_reg.write_y) < side);
    end

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            tprod[c] = tex_reg[8*c +: 8] * w_reg;
            rsum[c]  = acc_reg[c] + (mtx_pkg::ACC_W'(1) << 39);
            result[8*c +: 8] = rsum[c][47:40];
        end
    end

    // ------------------------------------------------------------------ control
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mtx_pkg::BK_IDLE: begin
                if (q_valid) begin
                    if (q_item.command == mtx_pkg::CMD_WRITE) begin
                        state_next = mtx_pkg::BK_WRITE;
                    end else if (cfg.level_method == mtx_pkg::LM_BASE) begin
                        state_next = mtx_pkg::BK_PICK;
                    end else begin
                        state_next = mtx_pkg::BK_SCALE;
                    end
                end
            end
            mtx_pkg::BK_WRITE:  state_next = mtx_pkg::BK_IDLE;
            mtx_pkg::BK_SCALE:  state_next = mtx_pkg::BK_SQUARE;
            mtx_pkg::BK_SQUARE: begin
                if (dsel_reg != 2'd3) begin
                    state_next = mtx_pkg::BK_SCALE;
                end else if (s_max == '0) begin
                    state_next = mtx_pkg::BK_PICK;
                end else begin
                    state_next = mtx_pkg::BK_NORM;
                end
            end
            mtx_pkg::BK_NORM: begin
                if (norm_reg[mtx_pkg::SUM_W-1]) begin
                    state_next = mtx_pkg::BK_LOG;
                end
            end
            mtx_pkg::BK_LOG: begin
                if (step_reg == 4'd8) begin
                    state_next = mtx_pkg::BK_PICK;
                end
            end
            mtx_pkg::BK_PICK:  state_next = mtx_pkg::BK_SETUP;
            mtx_pkg::BK_SETUP: state_next = mtx_pkg::BK_ADDR;
            mtx_pkg::BK_ADDR: begin
                priority if (!skip) begin
                    state_next = mtx_pkg::BK_WEIGHT;
                end else if (!last_tex) begin
                    state_next = mtx_pkg::BK_ADDR;
                end else if (need_upper) begin
                    state_next = mtx_pkg::BK_SETUP;
                end else begin
                    state_next = mtx_pkg::BK_DONE;
                end
            end
            mtx_pkg::BK_WEIGHT: state_next = mtx_pkg::BK_ACCUM;
            mtx_pkg::BK_ACCUM: begin
                priority if (!last_tex) begin
                    state_next = mtx_pkg::BK_ADDR;
                end else if (need_upper) begin
                    state_next = mtx_pkg::BK_SETUP;
                end else begin
                    state_next = mtx_pkg::BK_DONE;
                end
            end
            mtx_pkg::BK_DONE: begin
                if (out_free) begin
                    state_next = mtx_pkg::BK_IDLE;
                end
            end
            default: state_next = mtx_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        q_pop  = (state_reg == mtx_pkg::BK_IDLE);
        mem_we = (state_reg == mtx_pkg::BK_WRITE) && wr_ok && addr_ok;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= mtx_pkg::BK_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == mtx_pkg::BK_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------ memory
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[addr_full[mtx_pkg::ADDR_W-1:0]] <= item_reg.texel_value;
        end
        rdata_reg <= mem[addr_full[mtx_pkg::ADDR_W-1:0]];
    end

    // ------------------------------------------------------------------ payload
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            mtx_pkg::BK_IDLE: begin
                item_reg     <= q_item;
                dsel_reg     <= '0;
                sx_reg       <= '0;
                sy_reg       <= '0;
                lvl_zero_reg <= 1'b1;
            end
            mtx_pkg::BK_SCALE: mag_reg <= mag;
            mtx_pkg::BK_SQUARE: begin
                if (!dsel_reg[1]) begin
                    sx_reg <= sx_reg + mtx_pkg::SUM_W'(sq);
                end else begin
                    sy_reg <= sy_new;
                end
                dsel_reg <= dsel_reg + 2'd1;
                norm_reg <= s_max;
                e_reg    <= mtx_pkg::E_W'(mtx_pkg::SUM_W - 1);
            end
            mtx_pkg::BK_NORM: begin
                // skip a zero byte at a time, then single bits
                priority if (norm_reg[mtx_pkg::SUM_W-1 -: 8] == '0) begin
                    norm_reg <= norm_reg << 8;
                    e_reg    <= e_reg - mtx_pkg::E_W'(8);
                end else if (!norm_reg[mtx_pkg::SUM_W-1]) begin
                    norm_reg <= norm_reg << 1;
                    e_reg    <= e_reg - mtx_pkg::E_W'(1);
                end else begin
                    m_reg    <= norm_reg[mtx_pkg::SUM_W-1 -: 32];
                    frac_reg <= '0;
                    step_reg <= '0;
                end
            end
            mtx_pkg::BK_LOG: begin
                m_reg    <= mtop[32] ? mtop[32:1] : mtop[31:0];
                frac_reg <= {frac_reg[7:0], mtop[32]};
                step_reg <= step_reg + 4'd1;
                if (step_reg == 4'd8) begin
                    lvl_zero_reg <= 1'b0;
                end
            end
            mtx_pkg::BK_PICK: begin
                unique case (cfg.level_method)
                    mtx_pkg::LM_NEAREST: begin
                        lower_reg <= lvl_round[11:8];
                        upper_reg <= lvl_round[11:8];
                        ratio_reg <= '0;
                    end
                    mtx_pkg::LM_LINEAR: begin
                        lower_reg <= lvl8[11:8];
                        upper_reg <= lvl8[11:8] + 4'((lvl8[7:0] != '0));
                        ratio_reg <= lvl8[7:0];
                    end
                    default: begin
                        lower_reg <= '0;
                        upper_reg <= '0;
                        ratio_reg <= '0;
                    end
                endcase
                j_reg <= 1'b0;
                for (int c = 0; c < 4; c++) begin
                    acc_reg[c] <= '0;
                end
            end
            mtx_pkg::BK_SETUP: begin
                k_reg <= '0;
                if (cfg.pixel_method == mtx_pkg::PM_NEAREST) begin
                    x0_reg <= nx;
                    x1_reg <= nx;
                    y0_reg <= ny;
                    y1_reg <= ny;
                    au_reg <= '0;
                    av_reg <= '0;
                end else begin
                    x0_reg <= bx0;
                    x1_reg <= bx1;
                    y0_reg <= by0;
                    y1_reg <= by1;
                    au_reg <= pu[15:0];
                    av_reg <= pv[15:0];
                end
            end
            mtx_pkg::BK_ADDR: begin
                wxy_reg     <= wx * wy;
                inrange_reg <= addr_ok;
                if (skip) begin
                    k_reg <= k_reg + 2'd1;
                    if (last_tex) begin
                        j_reg <= 1'b1;
                    end
                end
            end
            mtx_pkg::BK_WEIGHT: begin
                w_reg   <= wxy_reg * wl8;
                tex_reg <= inrange_reg ? rdata_reg : '0;
            end
            mtx_pkg::BK_ACCUM: begin
                for (int c = 0; c < 4; c++) begin
                    acc_reg[c] <= acc_reg[c] + tprod[c][mtx_pkg::ACC_W-1:0];
                end
                k_reg <= k_reg + 2'd1;
                if (last_tex) begin
                    j_reg <= 1'b1;
                end
            end
            mtx_pkg::BK_DONE: begin
                if (out_free) begin
                    m_tdata_reg <= result;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- rtl/mtx_checker.sv -----
// ----------------------------------------------------------------------------
// mtx_checker
// Port-level checks of the mipmap texture sampler, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "mipmap_texture_sampler_defines.svh"

module mtx_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        cfg_valid,
    input logic        cfg_ready
);

    `MTX_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
    `MTX_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata))
    `MTX_ASSERT_NOW(a_cfg_taken, cfg_valid, cfg_ready)
    `MTX_ASSERT_NOW(a_reset_empty, !$past(aresetn), !m_tvalid && (s_tready || !s_tvalid))

endmodule

bind mipmap_texture_sampler mtx_checker u_mtx_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);
